[hw/rtl/hebld_pkg.sv]
// Shared types, constants and helpers for the hit event builder.
`timescale 1ns / 1ps

package hebld_pkg;

	localparam int NUM_LAYERS_DEF    = 4;
	localparam int NUM_BOARD_IDS_DEF = 16;
	localparam int TIME_BITS_DEF     = 48;

	localparam int MAX_LAYERS   = 4;
	localparam int BOARD_BITS   = 4;
	localparam int LAYER_BITS   = 2;
	localparam int CNT_BITS     = 8;
	localparam int FRAME_BITS   = 32;
	localparam int EVNUM_BITS   = 32;
	localparam int GAP_OUT_BITS = 48;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int QUEUE_DEPTH  = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_GAP_TICKS        = 3'd0,
		REG_TRIGGER_LOW      = 3'd1,
		REG_TRIGGER_HIGH     = 3'd2,
		REG_FRAME_MODE       = 3'd3,
		REG_DROP_ZERO_WIDTH  = 3'd4,
		REG_BOARD_KNOWN_MASK = 3'd5,
		REG_BOARD_LAYER_MAP  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] gap_ticks;
		logic [7:0]  trigger_low;
		logic [7:0]  trigger_high;
		logic        frame_mode;
		logic        drop_zero_width;
		logic [15:0] board_known_mask;
		logic [31:0] board_layer_map;
	} cfg_t;

	// classified hit as it travels from front to back (time gap carried alongside)
	typedef struct packed {
		logic                  set_frame;   // first word since reset: load open frame
		logic                  is_hit;      // clear for a dropped first hit
		logic [FRAME_BITS-1:0] frame;
		logic                  count_layer; // known board with a layer in range
		logic [LAYER_BITS-1:0] layer;
	} hit_word_t;

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
		sat_inc = (v == {CNT_BITS{1'b1}}) ? v : v + CNT_BITS'(1);
	endfunction

endpackage

[hw/rtl/hit_event_builder_top.sv]
// Top level of the hit event builder: configuration registers, front, queue and back.
`timescale 1ns / 1ps

// Hit event builder. Hits (timestamp, board id, pulse width, frame) come in one
// word per cycle while in_ready is high on the in_ channel and are grouped into
// events. In gap mode a hit more than gap_ticks away from the previous hit closes
// the open event; in frame mode a change of frame closes it. The closing hit opens
// the next event. A closed event goes out on the out_ channel if trigger_low <
// hits < trigger_high, or always in frame mode; the last open event is never sent.
// Per event the block reports total hits, hits per layer (via the board to
// layer map), the number of layers hit, the gap to the closing hit and the
// event's frame; the hit counters stop at 255. With drop_zero_width set, hits of
// zero pulse width are ignored, though the first hit after reset still fixes
// the starting frame. Unknown boards count only in the total.
// Throughput: one hit per cycle while in_ready is high. The front works out the
// time gap and layer in the accept cycle and writes a two-word queue; the back
// pops one word per cycle unless stalled, and out_valid is registered once the
// closing hit is popped. The back stalls only while a finished event waits in
// the output register; the queue then fills to two words before in_ready drops.
// Configuration is written through cfg_we/cfg_index/cfg_data and must only be
// changed while the block is idle; there is no read-back.

module hit_event_builder_top #(
	parameter int NUM_LAYERS    = hebld_pkg::NUM_LAYERS_DEF,
	parameter int NUM_BOARD_IDS = hebld_pkg::NUM_BOARD_IDS_DEF,
	parameter int TIME_BITS     = hebld_pkg::TIME_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [hebld_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [hebld_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// hit words in
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [TIME_BITS-1:0]                  hit_time,
	input  logic [hebld_pkg::BOARD_BITS-1:0]      board_id,
	input  logic [15:0]                           pulse_width,
	input  logic [hebld_pkg::FRAME_BITS-1:0]      frame_number,
	// event words out
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [hebld_pkg::EVNUM_BITS-1:0]      event_number,
	output logic [hebld_pkg::CNT_BITS-1:0]        hit_total,
	output logic [hebld_pkg::CNT_BITS-1:0]        layer0_hits,
	output logic [hebld_pkg::CNT_BITS-1:0]        layer1_hits,
	output logic [hebld_pkg::CNT_BITS-1:0]        layer2_hits,
	output logic [hebld_pkg::CNT_BITS-1:0]        layer3_hits,
	output logic [2:0]                            layers_hit,
	output logic [hebld_pkg::GAP_OUT_BITS-1:0]    gap_after,
	output logic [hebld_pkg::FRAME_BITS-1:0]      event_frame
);

	localparam int QW = TIME_BITS + $bits(hebld_pkg::hit_word_t);

	hebld_pkg::cfg_t      cfg_q;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_push;
	logic                 q_pop;
	logic [TIME_BITS-1:0] push_diff;
	logic [TIME_BITS-1:0] pop_diff;
	hebld_pkg::hit_word_t push_word;
	hebld_pkg::hit_word_t pop_word;
	logic [QW-1:0]        q_rdata;

	// configuration registers, reset to their documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_ticks        <= 32'd1000;
			cfg_q.trigger_low      <= 8'd0;
			cfg_q.trigger_high     <= 8'd255;
			cfg_q.frame_mode       <= 1'b0;
			cfg_q.drop_zero_width  <= 1'b0;
			cfg_q.board_known_mask <= 16'hFFFF;
			cfg_q.board_layer_map  <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hebld_pkg::REG_GAP_TICKS:        cfg_q.gap_ticks        <= cfg_data;
				hebld_pkg::REG_TRIGGER_LOW:      cfg_q.trigger_low      <= cfg_data[7:0];
				hebld_pkg::REG_TRIGGER_HIGH:     cfg_q.trigger_high     <= cfg_data[7:0];
				hebld_pkg::REG_FRAME_MODE:       cfg_q.frame_mode       <= cfg_data[0];
				hebld_pkg::REG_DROP_ZERO_WIDTH:  cfg_q.drop_zero_width  <= cfg_data[0];
				hebld_pkg::REG_BOARD_KNOWN_MASK: cfg_q.board_known_mask <= cfg_data[15:0];
				hebld_pkg::REG_BOARD_LAYER_MAP:  cfg_q.board_layer_map  <= cfg_data;
				default: ; // writes beyond the register list are ignored
			endcase
		end
	end

	hebld_front #(
		.NUM_LAYERS    (NUM_LAYERS),
		.NUM_BOARD_IDS (NUM_BOARD_IDS),
		.TIME_BITS     (TIME_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.hit_time     (hit_time),
		.board_id     (board_id),
		.pulse_width  (pulse_width),
		.frame_number (frame_number),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_diff       (push_diff),
		.q_word       (push_word)
	);

	hebld_fifo #(
		.WIDTH (QW),
		.DEPTH (hebld_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({push_diff, push_word}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign pop_diff = q_rdata[QW-1 -: TIME_BITS];
	assign pop_word = q_rdata[$bits(hebld_pkg::hit_word_t)-1:0];

	hebld_back #(
		.NUM_LAYERS (NUM_LAYERS),
		.TIME_BITS  (TIME_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_diff       (pop_diff),
		.q_word       (pop_word),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_number (event_number),
		.hit_total    (hit_total),
		.layer0_hits  (layer0_hits),
		.layer1_hits  (layer1_hits),
		.layer2_hits  (layer2_hits),
		.layer3_hits  (layer3_hits),
		.layers_hit   (layers_hit),
		.gap_after    (gap_after),
		.event_frame  (event_frame)
	);

endmodule

[hw/rtl/hebld_front.sv]
// Front end: accepts hits, drops zero-width hits if enabled, works out time gap and layer.
`timescale 1ns / 1ps

module hebld_front #(
	parameter int NUM_LAYERS    = hebld_pkg::NUM_LAYERS_DEF,
	parameter int NUM_BOARD_IDS = hebld_pkg::NUM_BOARD_IDS_DEF,
	parameter int TIME_BITS     = hebld_pkg::TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hebld_pkg::cfg_t                     cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [TIME_BITS-1:0]                hit_time,
	input  logic [hebld_pkg::BOARD_BITS-1:0]    board_id,
	input  logic [15:0]                         pulse_width,
	input  logic [hebld_pkg::FRAME_BITS-1:0]    frame_number,
	input  logic                                q_full,
	output logic                                q_push,
	output logic [TIME_BITS-1:0]                q_diff,
	output hebld_pkg::hit_word_t                q_word
);

	logic                 prev_valid_q;
	logic [TIME_BITS-1:0] prev_time_q;
	logic                 have_frame_q;
	logic                 accept;
	logic                 dropped;
	logic                 board_known;
	logic [hebld_pkg::LAYER_BITS-1:0] layer;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign dropped  = cfg.drop_zero_width && (pulse_width == '0);

	// board b owns bits 2b+1..2b of the map
	assign layer = cfg.board_layer_map[board_id*hebld_pkg::LAYER_BITS +: hebld_pkg::LAYER_BITS];
	assign board_known = ({1'b0, board_id} < (hebld_pkg::BOARD_BITS+1)'(NUM_BOARD_IDS))
		&& cfg.board_known_mask[board_id];

	always_comb begin
		q_diff = '0;
		if (prev_valid_q) begin
			q_diff = (hit_time >= prev_time_q) ? hit_time - prev_time_q : prev_time_q - hit_time;
		end
	end

	// a dropped hit only travels on when it is the first one, to fix the frame
	assign q_push = accept && (!dropped || !have_frame_q);

	always_comb begin
		q_word.set_frame   = !have_frame_q;
		q_word.is_hit      = !dropped;
		q_word.frame       = frame_number;
		q_word.count_layer = board_known && ({1'b0, layer} < (hebld_pkg::LAYER_BITS+1)'(NUM_LAYERS));
		q_word.layer       = layer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			have_frame_q <= 1'b0;
		end else if (accept) begin
			have_frame_q <= 1'b1;
			if (!dropped) begin
				prev_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !dropped) begin
			prev_time_q <= hit_time;
		end
	end

endmodule

[hw/rtl/hebld_fifo.sv]
// Short word queue between front and back.
`timescale 1ns / 1ps

module hebld_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = hebld_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) (push && full) |-> pop)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");

endmodule

[hw/rtl/hebld_back.sv]
// Back end: event counters, close decision, trigger and output register.
`timescale 1ns / 1ps

module hebld_back #(
	parameter int NUM_LAYERS = hebld_pkg::NUM_LAYERS_DEF,
	parameter int TIME_BITS  = hebld_pkg::TIME_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hebld_pkg::cfg_t                       cfg,
	input  logic                                  q_empty,
	input  logic [TIME_BITS-1:0]                  q_diff,
	input  hebld_pkg::hit_word_t                  q_word,
	output logic                                  q_pop,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [hebld_pkg::EVNUM_BITS-1:0]      event_number,
	output logic [hebld_pkg::CNT_BITS-1:0]        hit_total,
	output logic [hebld_pkg::CNT_BITS-1:0]        layer0_hits,
	output logic [hebld_pkg::CNT_BITS-1:0]        layer1_hits,
	output logic [hebld_pkg::CNT_BITS-1:0]        layer2_hits,
	output logic [hebld_pkg::CNT_BITS-1:0]        layer3_hits,
	output logic [2:0]                            layers_hit,
	output logic [hebld_pkg::GAP_OUT_BITS-1:0]    gap_after,
	output logic [hebld_pkg::FRAME_BITS-1:0]      event_frame
);

	localparam int CW = hebld_pkg::CNT_BITS;
	localparam int MAXL = hebld_pkg::MAX_LAYERS;

	logic [CW-1:0]                    total_q;
	logic [CW-1:0]                    lay_q [NUM_LAYERS];
	logic [hebld_pkg::FRAME_BITS-1:0] open_frame_q;
	logic [hebld_pkg::EVNUM_BITS-1:0] emitted_q;
	logic                             out_valid_q;

	logic [CW-1:0]                    lay_ext [MAXL];
	logic [MAXL-1:0]                  lay_nz;
	logic [2:0]                       nz_count;
	logic [63:0]                      diff64;
	logic [hebld_pkg::GAP_OUT_BITS-1:0] gap_sat;
	logic [hebld_pkg::FRAME_BITS-1:0] cur_frame;
	logic                             close;
	logic                             emit;
	logic                             hit_step;
	logic                             load;

	assign q_pop    = !q_empty && (!out_valid_q || out_ready);
	assign hit_step = q_pop && q_word.is_hit;
	assign diff64   = 64'(q_diff);
	assign gap_sat  = (diff64[63:hebld_pkg::GAP_OUT_BITS] != '0) ? '1
		: diff64[hebld_pkg::GAP_OUT_BITS-1:0];
	assign cur_frame = q_word.set_frame ? q_word.frame : open_frame_q;

	always_comb begin
		if (cfg.frame_mode) begin
			close = (cur_frame != q_word.frame);
		end else begin
			close = (total_q != '0) && (diff64 > 64'(cfg.gap_ticks));
		end
		emit = close && (cfg.frame_mode ||
			((cfg.trigger_low < total_q) && (total_q < cfg.trigger_high)));
	end

	assign load = hit_step && emit;

	// unused layer slots read as zero
	for (genvar gk = 0; gk < MAXL; gk++) begin : g_ext
		if (gk < NUM_LAYERS) begin : g_used
			assign lay_ext[gk] = lay_q[gk];
		end else begin : g_unused
			assign lay_ext[gk] = '0;
		end
		assign lay_nz[gk] = (lay_ext[gk] != '0);
	end

	always_comb begin
		nz_count = '0;
		for (int k = 0; k < MAXL; k++) begin
			nz_count = nz_count + 3'(lay_nz[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			open_frame_q <= '0;
			emitted_q    <= '0;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < NUM_LAYERS; k++) begin
				lay_q[k] <= '0;
			end
		end else begin
			if (q_pop) begin
				open_frame_q <= (q_word.is_hit && close) ? q_word.frame : cur_frame;
			end
			if (hit_step) begin
				total_q <= hebld_pkg::sat_inc(close ? '0 : total_q);
				for (int k = 0; k < NUM_LAYERS; k++) begin
					if (q_word.count_layer && (q_word.layer == hebld_pkg::LAYER_BITS'(k))) begin
						lay_q[k] <= hebld_pkg::sat_inc(close ? '0 : lay_q[k]);
					end else if (close) begin
						lay_q[k] <= '0;
					end
				end
			end
			if (load) begin
				emitted_q   <= emitted_q + hebld_pkg::EVNUM_BITS'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			event_number <= emitted_q;
			hit_total    <= total_q;
			layer0_hits  <= lay_ext[0];
			layer1_hits  <= lay_ext[1];
			layer2_hits  <= lay_ext[2];
			layer3_hits  <= lay_ext[3];
			layers_hit   <= nz_count;
			gap_after    <= gap_sat;
			event_frame  <= open_frame_q;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> emitted_q == $past(emitted_q) + hebld_pkg::EVNUM_BITS'(1))
		else $error("event number not advanced on emit");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !load)
		else $error("held event overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (hit_total >= layer0_hits && hit_total >= layer1_hits &&
			hit_total >= layer2_hits && hit_total >= layer3_hits))
		else $error("layer count above event total");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> layers_hit <= 3'(NUM_LAYERS))
		else $error("more layers hit than exist");

endmodule
